// ----- rtl/core/sapd_pkg.sv -----
// Shared types and constants of the spectrum average/peak decimator.
`default_nettype none

package sapd_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int SUM_W     = 48;
  localparam int CNT_W     = 17;
  localparam int IDX_W     = 16;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0] MAX_FRAME_LENGTH = 17'd65536;
  localparam logic [CFG_W-1:0] FRAME_LENGTH_RST = 17'd65536;
  localparam logic [CFG_W-1:0] PLOT_LENGTH_RST  = 17'd2048;
  localparam logic [CNT_W-1:0] BINS_RST         = 17'd2048;

  // -1000 dB in Q23.8
  localparam logic signed [SAMPLE_W-1:0] PEAK_FLOOR = -32'sd256000;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  localparam int DIV_STEPS = 48;
  localparam int DIV_CNT_W = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_LENGTH = 1'b0,
    REG_PLOT_LENGTH  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_W-1:0]           bin_index;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SAMPLE_W-1:0] peak;
    logic                       last_bin;
    logic [CNT_W-1:0]           spb;
  } bin_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/sapd_if.sv -----
// Stream interfaces for the sample input and bin result channels.
`default_nettype none

interface sapd_in_if;
  logic                        valid;
  logic                        ready;
  logic signed [sapd_pkg::SAMPLE_W-1:0] power_sample;

  modport source (output valid, output power_sample, input ready);
  modport sink   (input valid, input power_sample, output ready);
endinterface

interface sapd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [sapd_pkg::IDX_W-1:0]           bin_index;
  logic signed [sapd_pkg::SAMPLE_W-1:0] bin_mean;
  logic signed [sapd_pkg::SAMPLE_W-1:0] bin_peak;
  logic                                 last_bin;

  modport source (output valid, output bin_index, output bin_mean, output bin_peak,
                  output last_bin, input ready);
  modport sink   (input valid, input bin_index, input bin_mean, input bin_peak,
                  input last_bin, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sapd_udiv.sv -----
// Restoring unsigned divider, 48-bit dividend by 17-bit divisor, one bit per cycle.
`default_nettype none

module sapd_udiv (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [sapd_pkg::SUM_W-1:0]    dividend,
  input  wire logic [sapd_pkg::CNT_W-1:0]    divisor,
  output logic                               done,
  output logic [sapd_pkg::SUM_W-1:0]         quotient
);

  logic [sapd_pkg::CNT_W-1:0]     rem_r, rem_nxt;
  logic [sapd_pkg::SUM_W-1:0]     quo_r, quo_nxt;
  logic [sapd_pkg::CNT_W-1:0]     div_r;
  logic [sapd_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;
  logic [sapd_pkg::CNT_W:0]       trial;
  logic [sapd_pkg::CNT_W:0]       diff;
  logic                           ge;

  always_comb begin
    trial   = {rem_r, quo_r[sapd_pkg::SUM_W-1]};
    diff    = trial - {1'b0, div_r};
    ge      = (trial >= {1'b0, div_r});
    rem_nxt = ge ? diff[sapd_pkg::CNT_W-1:0] : trial[sapd_pkg::CNT_W-1:0];
    quo_nxt = {quo_r[sapd_pkg::SUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= sapd_pkg::DIV_CNT_W'(sapd_pkg::DIV_STEPS - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- rtl/core/sapd_queue.sv -----
// Short register queue of finished bins between front and back end.
`default_nettype none

module sapd_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire sapd_pkg::bin_entry_t entry_in,
  input  wire logic                 pop,
  output sapd_pkg::bin_entry_t      entry_out,
  output sapd_pkg::q_stat_t         stat
);

  sapd_pkg::bin_entry_t mem_r [sapd_pkg::Q_DEPTH];
  logic [sapd_pkg::Q_PTR_W-1:0] wr_ptr_r;
  logic [sapd_pkg::Q_PTR_W-1:0] rd_ptr_r;
  logic [sapd_pkg::Q_CNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= entry_in;
  end

  assign entry_out  = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == sapd_pkg::Q_CNT_W'(sapd_pkg::Q_DEPTH));
  assign stat.empty = (count_r == '0);

endmodule

`default_nettype wire

// ----- rtl/core/sapd_front.sv -----
// Front end: frame setup, sample accumulation and bin closing.
`default_nettype none

module sapd_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic [sapd_pkg::CFG_W-1:0]           frame_length,
  input  wire logic [sapd_pkg::CFG_W-1:0]           plot_length,
  input  wire logic                                 cfg_we,
  input  wire logic                                 in_valid,
  input  wire logic signed [sapd_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                      in_ready,
  input  wire sapd_pkg::q_stat_t                    q_stat,
  output logic                                      push,
  output sapd_pkg::bin_entry_t                      entry
);

  localparam int SW = sapd_pkg::SUM_W;
  localparam int CW = sapd_pkg::CNT_W;

  logic [CW-1:0]                     spb_r, spb_nxt;
  logic [CW-1:0]                     bins_r, bins_nxt;
  logic [CW-1:0]                     pos_bin_r, pos_bin_nxt;
  logic [CW-1:0]                     cur_bin_r, cur_bin_nxt;
  logic [CW-1:0]                     pos_frame_r, pos_frame_nxt;
  logic signed [SW-1:0]              sum_r, sum_nxt;
  logic signed [sapd_pkg::SAMPLE_W-1:0] peak_r, peak_nxt;
  logic                              setup_done_r, setup_done_nxt;
  logic                              setup_busy_r, setup_busy_nxt;

  logic [CW-1:0]                     flen_eff;
  logic [CW-1:0]                     plen_eff;
  logic                              div_start;
  logic                              div_done;
  logic [SW-1:0]                     div_quo;
  logic [CW-1:0]                     width_q;
  logic                              acc;
  logic signed [SW-1:0]              sum_add;
  logic signed [sapd_pkg::SAMPLE_W-1:0] peak_max;
  logic [CW-1:0]                     pos_bin_inc;
  logic [CW-1:0]                     pos_frame_inc;
  logic [CW-1:0]                     cur_bin_inc;
  logic                              active;
  logic                              bin_full;
  logic                              frame_end;

  always_comb begin
    if (frame_length == '0) flen_eff = CW'(1);
    else if (frame_length > sapd_pkg::MAX_FRAME_LENGTH) flen_eff = sapd_pkg::MAX_FRAME_LENGTH;
    else flen_eff = frame_length;
    plen_eff = (plot_length == '0) ? CW'(1) : plot_length;
  end

  // Bin width for the next frame, worked out before its first sample
  assign div_start = (pos_frame_r == '0) && !setup_done_r && !setup_busy_r && !cfg_we;
  assign width_q   = div_quo[CW-1:0];

  sapd_udiv u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({{(SW-CW){1'b0}}, flen_eff}),
    .divisor  (plen_eff),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_ready = ((pos_frame_r != '0) || setup_done_r) && !q_stat.full;
  assign acc      = in_valid && in_ready;

  always_comb begin
    sum_add       = sum_r + SW'(in_sample);
    peak_max      = (in_sample > peak_r) ? in_sample : peak_r;
    pos_bin_inc   = pos_bin_r + 1'b1;
    pos_frame_inc = pos_frame_r + 1'b1;
    cur_bin_inc   = cur_bin_r + 1'b1;
    active        = (cur_bin_r < bins_r);
    bin_full      = active && (pos_bin_inc >= spb_r);
    frame_end     = (pos_frame_inc >= flen_eff);
  end

  always_comb begin
    spb_nxt        = spb_r;
    bins_nxt       = bins_r;
    pos_bin_nxt    = pos_bin_r;
    cur_bin_nxt    = cur_bin_r;
    pos_frame_nxt  = pos_frame_r;
    sum_nxt        = sum_r;
    peak_nxt       = peak_r;
    setup_done_nxt = setup_done_r;
    setup_busy_nxt = setup_busy_r;

    if (div_start) setup_busy_nxt = 1'b1;
    if (setup_busy_r && div_done) begin
      setup_busy_nxt = 1'b0;
      setup_done_nxt = 1'b1;
      if (width_q == '0) begin
        spb_nxt  = CW'(1);
        bins_nxt = flen_eff;
      end else begin
        spb_nxt  = width_q;
        bins_nxt = plen_eff;
      end
    end

    if (acc) begin
      if (active) begin
        sum_nxt     = sum_add;
        peak_nxt    = peak_max;
        pos_bin_nxt = pos_bin_inc;
        if (bin_full) begin
          cur_bin_nxt = cur_bin_inc;
          pos_bin_nxt = '0;
          sum_nxt     = '0;
          peak_nxt    = sapd_pkg::PEAK_FLOOR;
        end
      end
      if (frame_end) begin
        pos_frame_nxt  = '0;
        cur_bin_nxt    = '0;
        pos_bin_nxt    = '0;
        sum_nxt        = '0;
        peak_nxt       = sapd_pkg::PEAK_FLOOR;
        setup_done_nxt = 1'b0;
      end else begin
        pos_frame_nxt = pos_frame_inc;
      end
    end

    // Drop any setup in flight on a register write: redo it with new values
    if (cfg_we) begin
      setup_done_nxt = 1'b0;
      setup_busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spb_r        <= CW'(1);
      bins_r       <= sapd_pkg::BINS_RST;
      pos_bin_r    <= '0;
      cur_bin_r    <= '0;
      pos_frame_r  <= '0;
      sum_r        <= '0;
      peak_r       <= sapd_pkg::PEAK_FLOOR;
      setup_done_r <= 1'b0;
      setup_busy_r <= 1'b0;
    end else begin
      spb_r        <= spb_nxt;
      bins_r       <= bins_nxt;
      pos_bin_r    <= pos_bin_nxt;
      cur_bin_r    <= cur_bin_nxt;
      pos_frame_r  <= pos_frame_nxt;
      sum_r        <= sum_nxt;
      peak_r       <= peak_nxt;
      setup_done_r <= setup_done_nxt;
      setup_busy_r <= setup_busy_nxt;
    end
  end

  assign push           = acc && bin_full;
  assign entry.bin_index = cur_bin_r[sapd_pkg::IDX_W-1:0];
  assign entry.sum      = sum_add;
  assign entry.peak     = peak_max;
  assign entry.last_bin = (cur_bin_inc == bins_r);
  assign entry.spb      = spb_r;

endmodule

`default_nettype wire

// ----- rtl/core/sapd_back.sv -----
// Back end: divides each bin sum by its width and drives the result register.
`default_nettype none

module sapd_back (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire sapd_pkg::bin_entry_t     q_entry,
  input  wire sapd_pkg::q_stat_t        q_stat,
  output logic                          pop,
  input  wire logic                     out_ready,
  output logic                          out_valid,
  output logic [sapd_pkg::IDX_W-1:0]    out_bin_index,
  output logic signed [sapd_pkg::SAMPLE_W-1:0] out_bin_mean,
  output logic signed [sapd_pkg::SAMPLE_W-1:0] out_bin_peak,
  output logic                          out_last_bin
);

  localparam int SW = sapd_pkg::SUM_W;
  localparam int DW = sapd_pkg::SAMPLE_W;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_DIV  = 2'b10
  } back_state_t;

  back_state_t state_r, state_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [sapd_pkg::IDX_W-1:0]    idx_r;
  logic signed [DW-1:0]          mean_r;
  logic signed [DW-1:0]          peak_r;
  logic                          last_r;

  logic [sapd_pkg::IDX_W-1:0]    h_idx_r;
  logic signed [DW-1:0]          h_peak_r;
  logic                          h_last_r;
  logic                          h_neg_r;

  logic                          slot_free;
  logic                          direct;
  logic                          div_start;
  logic                          div_done;
  logic [SW-1:0]                 div_quo;
  logic [SW-1:0]                 sum_mag;
  logic [DW-1:0]                 q_low;
  logic                          load_direct;
  logic                          load_div;

  assign slot_free = !out_valid_r || out_ready;
  assign direct    = (q_entry.spb == sapd_pkg::CNT_W'(1));
  assign sum_mag   = q_entry.sum[SW-1] ? SW'(-q_entry.sum) : SW'(q_entry.sum);
  assign q_low     = div_quo[DW-1:0];

  sapd_udiv u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (q_entry.spb),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt   = state_r;
    load_direct = 1'b0;
    load_div    = 1'b0;
    div_start   = 1'b0;
    pop         = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          if (direct) begin
            if (slot_free) begin
              load_direct = 1'b1;
              pop         = 1'b1;
            end
          end else begin
            div_start = 1'b1;
            pop       = 1'b1;
            state_nxt = B_DIV;
          end
        end
      end
      B_DIV: begin
        if (div_done && slot_free) begin
          load_div  = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    if (load_direct || load_div) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      h_idx_r  <= q_entry.bin_index;
      h_peak_r <= q_entry.peak;
      h_last_r <= q_entry.last_bin;
      h_neg_r  <= q_entry.sum[SW-1];
    end
    if (load_direct) begin
      idx_r  <= q_entry.bin_index;
      mean_r <= q_entry.sum[DW-1:0];
      peak_r <= q_entry.peak;
      last_r <= q_entry.last_bin;
    end else if (load_div) begin
      idx_r  <= h_idx_r;
      mean_r <= h_neg_r ? DW'(-q_low) : q_low;
      peak_r <= h_peak_r;
      last_r <= h_last_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_bin_index = idx_r;
  assign out_bin_mean  = mean_r;
  assign out_bin_peak  = peak_r;
  assign out_last_bin  = last_r;

endmodule

`default_nettype wire

// ----- rtl/core/spectrum_average_peak_decimator_core.sv -----
// Top level of the spectrum average/peak decimator.
//
// Usage: power samples (signed Q23.8) enter on in_if, one per transaction.
// Each frame of frame_length samples is cut into bins of
// frame_length / plot_length samples (at least one); for each bin one
// transaction on out_if carries its index, mean (truncated toward zero),
// peak (floored at -1000 dB) and a flag for the frame's final bin.
// Samples past the last whole bin are counted and dropped.
// Write frame_length (index 0) and plot_length (index 1) through cfg_we,
// cfg_index and cfg_wdata while no transaction is in flight.
// Frame setup: before the first sample of a frame, a 48-step serial divider
// works out the bin width; in_if.ready is low from the frame's last
// sample until that setup is through (start, 48 divide steps, finish).
// Within a frame one sample is taken per cycle while the bin queue
// (4 entries) has room. A bin of width one passes straight to the result
// register. Wider bins go through a second 48-step divider, one bin at a
// time: the next bin leaves the queue only once the last result is loaded,
// which sets the sustained rate for narrow bins.
// From a bin's last sample to out_if.valid the bin passes the queue and
// the result register, and for wider bins also the divider.
// Reset (rst_n low, synchronous) restores the register defaults, empties
// the queue and the result register. A stalled receiver holds the result
// register; the queue then fills and in_if.ready drops.
`default_nettype none

module spectrum_average_peak_decimator_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [sapd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sapd_pkg::CFG_W-1:0]         cfg_wdata,
  sapd_in_if.sink                                 in_if,
  sapd_out_if.source                              out_if
);

  logic [sapd_pkg::CFG_W-1:0] frame_length_r;
  logic [sapd_pkg::CFG_W-1:0] plot_length_r;

  sapd_pkg::bin_entry_t push_entry;
  sapd_pkg::bin_entry_t pop_entry;
  sapd_pkg::q_stat_t    q_stat;
  logic                 push;
  logic                 pop;
  logic                 in_ready;

  // Hold configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_length_r <= sapd_pkg::FRAME_LENGTH_RST;
      plot_length_r  <= sapd_pkg::PLOT_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sapd_pkg::REG_FRAME_LENGTH: frame_length_r <= cfg_wdata;
        sapd_pkg::REG_PLOT_LENGTH:  plot_length_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Front end: accept samples, accumulate, close bins into the queue
  sapd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_length (frame_length_r),
    .plot_length  (plot_length_r),
    .cfg_we       (cfg_we),
    .in_valid     (in_if.valid),
    .in_sample    (in_if.power_sample),
    .in_ready     (in_ready),
    .q_stat       (q_stat),
    .push         (push),
    .entry        (push_entry)
  );

  assign in_if.ready = in_ready;

  // Decouple the two sides
  sapd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .entry_in  (push_entry),
    .pop       (pop),
    .entry_out (pop_entry),
    .stat      (q_stat)
  );

  // Back end: divide and present results
  sapd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_entry       (pop_entry),
    .q_stat        (q_stat),
    .pop           (pop),
    .out_ready     (out_if.ready),
    .out_valid     (out_if.valid),
    .out_bin_index (out_if.bin_index),
    .out_bin_mean  (out_if.bin_mean),
    .out_bin_peak  (out_if.bin_peak),
    .out_last_bin  (out_if.last_bin)
  );

  // A sample is never taken while the queue cannot hold a closed bin
  a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |-> !q_stat.full)
    else $error("sample accepted with bin queue full");

  // A bin pushed is visible in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> !q_stat.empty)
    else $error("pushed bin missing from queue");

  // The back end only pops what is there
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty bin queue");

endmodule

`default_nettype wire

// ----- dv/sapd_bin_checker.sv -----
// Checker that predicts and compares the bin results of the average/peak decimator.
`timescale 1ns / 100ps

module sapd_bin_checker
  import sapd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  sapd_in_if                   in_mon,
  sapd_out_if                  out_mon,
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    logic [IDX_W-1:0]           bin_index;
    logic signed [SAMPLE_W-1:0] bin_mean;
    logic signed [SAMPLE_W-1:0] bin_peak;
    logic                       last_bin;
  } bin_result_t;

  bin_result_t bins_due[$];

  logic [CFG_W-1:0]           frame_len;
  logic [CFG_W-1:0]           plot_len;
  logic [CNT_W-1:0]           bin_width;
  logic [CNT_W-1:0]           bin_count;
  logic [CNT_W-1:0]           pos_in_bin;
  logic [CNT_W-1:0]           bin_no;
  logic [CNT_W-1:0]           pos_in_frame;
  logic signed [SUM_W-1:0]    acc_sum;
  logic signed [SAMPLE_W-1:0] acc_peak;

  task automatic clear_bin();
    pos_in_bin = '0;
    acc_sum    = '0;
    acc_peak   = PEAK_FLOOR;
  endtask

  task automatic reset_model();
    frame_len    = FRAME_LENGTH_RST;
    plot_len     = PLOT_LENGTH_RST;
    bin_width    = 17'd1;
    bin_count    = BINS_RST;
    bin_no       = '0;
    pos_in_frame = '0;
    clear_bin();
  endtask

  // Advance the model by one accepted sample; queue a result when a bin closes.
  task automatic predict_bin(input logic signed [SAMPLE_W-1:0] sample);
    logic [CNT_W-1:0]        flen;
    logic [CNT_W-1:0]        plen;
    logic [CNT_W-1:0]        width_q;
    logic signed [SUM_W-1:0] mean;
    bin_result_t             res;
    flen = frame_len;
    if (flen == '0) begin
      flen = 17'd1;
    end else if (flen > MAX_FRAME_LENGTH) begin
      flen = MAX_FRAME_LENGTH;
    end
    if (pos_in_frame == '0) begin
      plen    = (plot_len == '0) ? 17'd1 : plot_len;
      width_q = flen / plen;
      if (width_q == '0) begin
        bin_width = 17'd1;
        bin_count = flen;
      end else begin
        bin_width = width_q;
        bin_count = plen;
      end
      bin_no = '0;
      clear_bin();
    end
    if (bin_no < bin_count) begin
      acc_sum = acc_sum + SUM_W'(sample);
      if (sample > acc_peak) acc_peak = sample;
      pos_in_bin = pos_in_bin + 1'b1;
      if (pos_in_bin >= bin_width) begin
        mean          = acc_sum / $signed({1'b0, bin_width});
        res.bin_index = bin_no[IDX_W-1:0];
        res.bin_mean  = mean[SAMPLE_W-1:0];
        res.bin_peak  = acc_peak;
        res.last_bin  = (bin_no + 1'b1 == bin_count);
        bins_due.push_back(res);
        bin_no = bin_no + 1'b1;
        clear_bin();
      end
    end
    pos_in_frame = pos_in_frame + 1'b1;
    if (pos_in_frame >= flen) begin
      pos_in_frame = '0;
      bin_no       = '0;
      clear_bin();
    end
  endtask

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endfunction

  initial reset_model();

  always @(posedge clk) begin : watch
    bin_result_t want;
    if (!rst_n) begin
      reset_model();
      bins_due.delete();
    end else begin
      // A sample taken at a write edge still sees the old register values
      if (in_mon.valid && in_mon.ready) predict_bin(in_mon.power_sample);
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_LENGTH: frame_len = cfg_wdata;
          REG_PLOT_LENGTH:  plot_len  = cfg_wdata;
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (bins_due.size() == 0) begin
          fail_count++;
          $display("%0t: bin result with none expected, expected nothing actual %h/%h/%h/%b",
                   $time, out_mon.bin_index, out_mon.bin_mean, out_mon.bin_peak,
                   out_mon.last_bin);
        end else begin
          want = bins_due.pop_front();
          compare_field("bin_index", 32'(want.bin_index), 32'(out_mon.bin_index));
          compare_field("bin_mean", want.bin_mean, out_mon.bin_mean);
          compare_field("bin_peak", want.bin_peak, out_mon.bin_peak);
          compare_field("last_bin", 32'(want.last_bin), 32'(out_mon.last_bin));
        end
      end
    end
    pending <= bins_due.size();
  end

endmodule

// ----- dv/tb_spectrum_average_peak_decimator_core.sv -----
// Top of the decimator testbench: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 100ps

module tb_spectrum_average_peak_decimator_core;
  import sapd_pkg::*;

  // Run length guard, far above the slowest legal run (divider-bound bins,
  // long gaps on both sides, frame setup before every frame).
  localparam int CYCLE_LIMIT      = 3_000_000;
  // Cycles to let pass once the last expected bin has arrived, so that the
  // serial frame setup that follows has finished.
  localparam int DRAIN_PAD        = 64;
  // Length of the forced receiver hold-off used to back the block up.
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS     = 1550;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  cfg_reg_t         cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  sapd_in_if  sample_ch ();
  sapd_out_if bin_ch ();

  int fail_count;
  int pending;
  int cycle_count;

  // Shared stimulus controls: written by the sender process only.
  logic no_idle;
  int   long_hold_requests;

  spectrum_average_peak_decimator_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_if     (sample_ch),
    .out_if    (bin_ch)
  );

  sapd_bin_checker bin_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_mon     (sample_ch),
    .out_mon    (bin_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Gap length for either side: mostly none, some short, a few long.
  // Inside a no-idle stretch both sides run back to back.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Effective frame span of a frame_length value (zero and oversize clamp).
  function automatic int unsigned frame_span(logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_FRAME_LENGTH) return 32'(MAX_FRAME_LENGTH);
    return 32'(v);
  endfunction

  // Power sample mix: raw random words for bit coverage, values around zero,
  // values straddling the -1000 dB floor, extremes, and typical dB levels.
  function automatic logic signed [SAMPLE_W-1:0] rand_power();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom();
    if (r < 55) return $urandom_range(0, 2000) - 1000;
    if (r < 70) return PEAK_FLOOR + $urandom_range(0, 8) - 4;
    if (r < 82) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7FFF_FFFF;
        1: return 32'sh8000_0000;
        2: return 32'sh0000_0000;
        default: return -32'sd1;
      endcase
    end
    return 32'd0 - $urandom_range(0, 150 * 256);
  endfunction

  // Offer one sample and hold it until the block takes the transaction.
  // Valid is lowered only when a gap is inserted, so it never toggles
  // twice in one time step.
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] sample);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid        <= 1'b1;
    sample_ch.power_sample <= sample;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
  endtask

  // Register write; the trailing cycle keeps back-to-back writes from
  // raising and lowering cfg_we in the same step.
  task automatic write_reg(input cfg_reg_t which, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering, wait for every predicted bin, then let the back end drain.
  task automatic settle();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // Receiver: random ready stalls, plus a long hold-off whenever the sender
  // asks for one. The hold is counted here so the sender keeps offering.
  initial begin : receiver
    int unsigned stall;
    int          served;
    served = 0;
    bin_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_requests != served) begin
        served++;
        bin_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          bin_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        bin_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: a run that outlives the limit is a failure.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("spectrum_average_peak_decimator_core verification failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned      span;
    int unsigned      frames;
    int unsigned      count;
    int unsigned      r;
    int unsigned      random_sent;
    logic [CFG_W-1:0] frame_v;
    logic [CFG_W-1:0] plot_v;
    logic [CFG_W-1:0] cur_frame;

    rst_n                  <= 1'b0;
    cfg_we                 <= 1'b0;
    cfg_index              <= REG_FRAME_LENGTH;
    cfg_wdata              <= '0;
    sample_ch.valid        <= 1'b0;
    sample_ch.power_sample <= '0;
    no_idle                <= 1'b0;
    long_hold_requests     <= 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extremes of the sample: two full-scale bins of width two. The negative
    // bin's peak sits on the -1000 dB floor.
    write_reg(REG_FRAME_LENGTH, 17'd4);
    write_reg(REG_PLOT_LENGTH, 17'd2);
    push_sample(32'sh7FFF_FFFF);
    push_sample(32'sh7FFF_FFFF);
    push_sample(32'sh8000_0000);
    push_sample(32'sh8000_0000);
    settle();

    // Width three, two bins, one tail sample dropped. First bin checks that
    // a negative mean truncates toward zero; second straddles the floor.
    write_reg(REG_FRAME_LENGTH, 17'd7);
    write_reg(REG_PLOT_LENGTH, 17'd2);
    push_sample(-32'sd1);
    push_sample(-32'sd1);
    push_sample(32'sd0);
    push_sample(-32'sd256001);
    push_sample(-32'sd256000);
    push_sample(-32'sd255999);
    push_sample(32'sh1234_5678);
    settle();

    // More bins requested than samples: width one, one bin per sample.
    write_reg(REG_PLOT_LENGTH, 17'd7);
    write_reg(REG_FRAME_LENGTH, 17'd3);
    push_sample(-32'sd256001);
    push_sample(32'sd1);
    push_sample(-32'sd3);
    settle();

    // Zero frame and plot lengths both count as one.
    write_reg(REG_FRAME_LENGTH, 17'd0);
    write_reg(REG_PLOT_LENGTH, 17'd0);
    push_sample(32'sd5);
    push_sample(-32'sd5);
    settle();

    // Oversize frame length clamps to the maximum; cut the frame short by
    // shrinking frame_length mid-frame, so it ends without a last bin.
    write_reg(REG_FRAME_LENGTH, 17'h1FFFF);
    write_reg(REG_PLOT_LENGTH, 17'd65536);
    push_sample(rand_power());
    push_sample(rand_power());
    push_sample(rand_power());
    settle();
    write_reg(REG_FRAME_LENGTH, 17'd2);
    push_sample(rand_power());
    settle();

    // Back-pressure: width-one bins while the receiver holds off, so the bin
    // queue fills and the input stalls with a sample still on offer.
    write_reg(REG_FRAME_LENGTH, 17'd40);
    write_reg(REG_PLOT_LENGTH, 17'd40);
    cur_frame = 17'd40;
    no_idle            <= 1'b1;
    long_hold_requests <= long_hold_requests + 1;
    repeat (40) push_sample(rand_power());
    no_idle <= 1'b0;
    settle();

    // Random phases. Each sends whole frames so that the next register
    // write lands on a frame boundary, except the cut-short phases.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // Long frame, a few samples, then end it by a smaller frame_length.
        case ($urandom_range(0, 2))
          0: frame_v = 17'd65536;
          1: frame_v = 17'h1FFFF;
          default: frame_v = CFG_W'($urandom_range(1000, 65536));
        endcase
        plot_v = ($urandom_range(0, 1) == 0) ? 17'd65536 : 17'($urandom_range(1, 65536));
        write_reg(REG_FRAME_LENGTH, frame_v);
        write_reg(REG_PLOT_LENGTH, plot_v);
        count = $urandom_range(1, 30);
        repeat (count) push_sample(rand_power());
        settle();
        cur_frame = CFG_W'($urandom_range(0, count + 1));
        write_reg(REG_FRAME_LENGTH, cur_frame);
        push_sample(rand_power());
        settle();
        random_sent += count + 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) frame_v = 17'd0;
        else if (r < 75) frame_v = CFG_W'($urandom_range(1, 24));
        else if (r < 95) frame_v = CFG_W'($urandom_range(25, 160));
        else frame_v = CFG_W'($urandom_range(161, 400));
        span = frame_span(frame_v);
        r = $urandom_range(0, 99);
        if (r < 8) plot_v = 17'd0;
        else if (r < 28) plot_v = CFG_W'($urandom_range(span + 1, span + 40));
        else plot_v = CFG_W'($urandom_range(1, span));
        // Keep the old frame_length or plot_length now and then.
        if ($urandom_range(0, 9) != 0) begin
          write_reg(REG_FRAME_LENGTH, frame_v);
          cur_frame = frame_v;
        end
        if ($urandom_range(0, 9) != 0) write_reg(REG_PLOT_LENGTH, plot_v);
        span   = frame_span(cur_frame);
        frames = $urandom_range(1, (span >= 120) ? 1 : 120 / span);
        no_idle <= ($urandom_range(0, 4) == 0);
        repeat (frames * span) push_sample(rand_power());
        no_idle <= 1'b0;
        settle();
        random_sent += frames * span;
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("spectrum_average_peak_decimator_core verification clean");
    end else begin
      $display("spectrum_average_peak_decimator_core verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/sapd_pkg.sv
rtl/core/sapd_if.sv
rtl/core/sapd_udiv.sv
rtl/core/sapd_queue.sv
rtl/core/sapd_front.sv
rtl/core/sapd_back.sv
rtl/core/spectrum_average_peak_decimator_core.sv
dv/sapd_bin_checker.sv
dv/tb_spectrum_average_peak_decimator_core.sv
